>>> src/modular_inverse_unit_macros.svh
// Assertion macros used by the modular inverse unit core.
`ifndef MODULAR_INVERSE_UNIT_MACROS_SVH
`define MODULAR_INVERSE_UNIT_MACROS_SVH

// Checks a condition in the same cycle as its trigger; clk and rst_n come from the module.
`define MIU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a condition in the cycle after its trigger.
`define MIU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/miu_pkg.sv
// Shared widths, types and state codes of the modular inverse unit.
package miu_pkg;

    localparam int WIDTH = 32;            // operand width used by the algorithm
    localparam int FIELD_W = 32;          // width of the value, modulus and inverse fields
    localparam int CW = WIDTH + 2;        // signed coefficient width
    localparam int CNT_W = $clog2(WIDTH); // division step counter width

    typedef logic [WIDTH-1:0] word_t;
    typedef logic signed [CW-1:0] coef_t;

    // One-hot sequencer states.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CHK  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_UPD  = 5'b01000,
        ST_FIN  = 5'b10000
    } state_t;

    // Operands of one restoring division step with its quotient-times-coefficient accumulation.
    typedef struct packed {
        word_t rem;
        logic  dividend_msb;
        word_t divisor;
        coef_t acc;
        coef_t coef;
    } step_in_t;

    typedef struct packed {
        word_t rem;
        coef_t acc;
    } step_out_t;

    // One finished result.
    typedef struct packed {
        logic [FIELD_W-1:0] inverse;
        logic               no_inverse;
    } result_t;

endpackage

>>> src/modular_inverse_unit.sv
// Modular inverse unit top level: stream ports, output register and the iterative core.
//
// Usage: an item on the slave stream carries a value and a modulus; one result item
// on the master stream carries the inverse of the value modulo the modulus, or 0 with
// tuser set when no inverse exists (shared factor or zero modulus with value above 1).
// A modulus of 1, or a value of 0 or 1, gives an inverse of 1.
// Each Euclid iteration runs a check state, the division state in which the shared
// one-bit-per-cycle divider and accumulator work through the quotient, and one
// coefficient update state. A modulus of 1, or a value of 0 or 1, needs no iteration.
// s_axis_tready is high only while the core is idle; one item is in work at a time,
// and the next item is taken in the cycle after the previous result enters the
// output register.
// The result sits in an output register, so the next item is accepted while an earlier
// result still waits. When the receiver stalls, a finished result holds inside the core
// until the register frees, and no new item is taken meanwhile.
// Reset clears the sequencer and the output valid flag; no item or result survives.
module modular_inverse_unit
    import miu_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [2*FIELD_W-1:0] s_axis_tdata,  // value, modulus
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [FIELD_W-1:0]   m_axis_tdata,  // inverse
    output logic                 m_axis_tuser   // no_inverse
);

    logic    core_ready;
    logic    core_done;
    logic    out_free;
    result_t core_result;
    word_t   value_w;
    word_t   modulus_w;

    logic               out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] out_data_reg, out_data_next;
    logic               out_user_reg, out_user_next;

    // Only the low WIDTH bits of each field take part in the computation.
    generate
        if (WIDTH <= FIELD_W)
        begin : g_in_trunc
            assign value_w   = s_axis_tdata[WIDTH-1:0];
            assign modulus_w = s_axis_tdata[FIELD_W+WIDTH-1:FIELD_W];
        end
        else
        begin : g_in_ext
            assign value_w   = {{(WIDTH - FIELD_W){1'b0}}, s_axis_tdata[FIELD_W-1:0]};
            assign modulus_w = {{(WIDTH - FIELD_W){1'b0}}, s_axis_tdata[2*FIELD_W-1:FIELD_W]};
        end
    endgenerate

    assign out_free = !out_valid_reg || m_axis_tready;

    miu_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_axis_tvalid),
        .value_in   (value_w),
        .modulus_in (modulus_w),
        .out_free   (out_free),
        .ready      (core_ready),
        .done       (core_done),
        .result     (core_result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (core_done)
        begin
            out_valid_next = 1'b1;
            out_data_next  = core_result.inverse;
            out_user_next  = core_result.no_inverse;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign s_axis_tready = core_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

>>> src/miu_step.sv
// One step of the shared unit: a restoring division bit plus the matching accumulation.
module miu_step
    import miu_pkg::*;
(
    input  step_in_t  step_in,
    output step_out_t step_out
);

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;
    logic           take;

    assign shifted = {step_in.rem, step_in.dividend_msb};
    assign diff    = shifted - {1'b0, step_in.divisor};
    assign take    = (shifted >= {1'b0, step_in.divisor});

    // The remainder after subtraction is below the divisor, so it fits the operand width.
    assign step_out.rem = take ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];

    // Quotient bits arrive MSB first, so quotient * coefficient builds up by shift and add.
    assign step_out.acc = {step_in.acc[CW-2:0], 1'b0} + (take ? step_in.coef : coef_t'(0));

endmodule

>>> src/miu_core.sv
// Sequencer and registers of the extended Euclidean iteration around the shared step unit.
`include "modular_inverse_unit_macros.svh"

module miu_core
    import miu_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  word_t   value_in,
    input  word_t   modulus_in,
    input  logic    out_free,
    output logic    ready,
    output logic    done,
    output result_t result
);

    state_t state_reg, state_next;
    word_t  a_reg, a_next;
    word_t  b_reg, b_next;
    word_t  b0_reg, b0_next;
    word_t  rem_reg, rem_next;
    word_t  dq_reg, dq_next;
    coef_t  x0_reg, x0_next;
    coef_t  x1_reg, x1_next;
    coef_t  acc_reg, acc_next;
    word_t  res_reg, res_next;
    logic   fail_reg, fail_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    step_in_t  step_in;
    step_out_t step_out;
    coef_t     corrected;
    logic      a_le_one;

    assign step_in.rem          = rem_reg;
    assign step_in.dividend_msb = dq_reg[WIDTH-1];
    assign step_in.divisor      = b_reg;
    assign step_in.acc          = acc_reg;
    assign step_in.coef         = x0_reg;

    miu_step u_step
    (
        .step_in  (step_in),
        .step_out (step_out)
    );

    assign a_le_one  = (a_reg[WIDTH-1:1] == '0);
    // A negative final coefficient is brought into range by one addition of the modulus.
    assign corrected = x1_reg[CW-1] ? (x1_reg + coef_t'({2'b00, b0_reg})) : x1_reg;

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        b0_next    = b0_reg;
        rem_next   = rem_reg;
        dq_next    = dq_reg;
        x0_next    = x0_reg;
        x1_next    = x1_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        fail_next  = fail_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_next  = value_in;
                    b_next  = modulus_in;
                    b0_next = modulus_in;
                    x0_next = '0;
                    x1_next = coef_t'(1);
                    if (modulus_in == word_t'(1))
                    begin
                        res_next   = word_t'(1);
                        fail_next  = 1'b0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_CHK;
                    end
                end
            end
            ST_CHK:
            begin
                if (a_le_one)
                begin
                    res_next   = corrected[WIDTH-1:0];
                    fail_next  = 1'b0;
                    state_next = ST_FIN;
                end
                else if (b_reg == '0)
                begin
                    res_next   = '0;
                    fail_next  = 1'b1;
                    state_next = ST_FIN;
                end
                else
                begin
                    rem_next   = '0;
                    dq_next    = a_reg;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = step_out.rem;
                acc_next = step_out.acc;
                dq_next  = {dq_reg[WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                a_next     = b_reg;
                b_next     = rem_reg;
                x0_next    = x1_reg - acc_reg;
                x1_next    = x0_reg;
                state_next = ST_CHK;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    done       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        b0_reg   <= b0_next;
        rem_reg  <= rem_next;
        dq_reg   <= dq_next;
        x0_reg   <= x0_next;
        x1_reg   <= x1_next;
        acc_reg  <= acc_next;
        res_reg  <= res_next;
        fail_reg <= fail_next;
        cnt_reg  <= cnt_next;
    end

    assign ready = (state_reg == ST_IDLE);

    generate
        if (WIDTH >= FIELD_W)
        begin : g_res_trunc
            assign result.inverse = res_reg[FIELD_W-1:0];
        end
        else
        begin : g_res_ext
            assign result.inverse = {{(FIELD_W - WIDTH){1'b0}}, res_reg};
        end
    endgenerate
    assign result.no_inverse = fail_reg;

    `MIU_ASSERT_SAME(a_rem_below_divisor, state_reg == ST_UPD, rem_reg < b_reg,
        "Division remainder is not below the divisor.")
    `MIU_ASSERT_SAME(a_divisor_nonzero, state_reg == ST_DIV, b_reg != '0,
        "Division started with a zero divisor.")
    `MIU_ASSERT_NEXT(a_start_moves_on, start && ready,
        state_reg == ST_CHK || state_reg == ST_FIN,
        "Accepted item did not start the sequencer.")
    `MIU_ASSERT_NEXT(a_result_waits, state_reg == ST_FIN && !out_free,
        state_reg == ST_FIN && $stable(res_reg) && $stable(fail_reg),
        "Finished result changed while the output slot was full.")

endmodule
